@@ hw/rtl/apcsr_pkg.sv @@
// Package for the cached ATA PIO sector reader: operation, result and phase codes,
// task file register offsets, status bits and the job descriptor.
// Depends on nothing; used by every module of the block.
`default_nettype none

package apcsr_pkg;

    typedef enum logic [1:0] {
        OP_REQUEST   = 2'd0,
        OP_BYTE_RESP = 2'd1,
        OP_WORD_RESP = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_WRITE = 3'd0,
        KIND_BREAD = 3'd1,
        KIND_WREAD = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_HIT   = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_ERROR = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DISCARD = 3'd1,
        PH_POLL    = 3'd2,
        PH_DATA    = 3'd3,
        PH_DUMMY   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        MODE_HIT        = 3'd0,
        MODE_CMD        = 3'd1,
        MODE_BREAD      = 3'd2,
        MODE_WREAD      = 3'd3,
        MODE_DONE       = 3'd4,
        MODE_ERROR      = 3'd5,
        MODE_DATA_WREAD = 3'd6,
        MODE_DATA_BREAD = 3'd7
    } mode_t;

    localparam logic [2:0] REG_DATA     = 3'd0;
    localparam logic [2:0] REG_COUNT    = 3'd2;
    localparam logic [2:0] REG_LBA_LOW  = 3'd3;
    localparam logic [2:0] REG_LBA_MID  = 3'd4;
    localparam logic [2:0] REG_LBA_HIGH = 3'd5;
    localparam logic [2:0] REG_STATUS   = 3'd7;
    localparam logic [2:0] REG_COMMAND  = 3'd7;

    localparam logic [7:0] CMD_READ_EXT = 8'h24;

    localparam int ST_BSY = 7;
    localparam int ST_DF  = 5;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [7:0] LAST_WORD   = 8'd255;
    localparam logic [2:0] DUMMY_READS = 3'd4;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] sector;
        logic [15:0] data_word;
        logic [24:0] word_address;
    } job_t;

    function automatic logic [3:0] mode_results(input mode_t mode);
        logic [3:0] n;
        unique case (mode)
            MODE_CMD:                         n = 4'd10;
            MODE_DATA_WREAD, MODE_DATA_BREAD: n = 4'd2;
            default:                          n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/apcsr_result_seq.sv @@
// Result sequencer: holds one job descriptor and delivers its result items one per cycle
// while m_tready is high. Depends on apcsr_pkg.
`default_nettype none

module apcsr_result_seq #(
    parameter int BURST_SECTORS = 8
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               job_valid,
    input  apcsr_pkg::job_t   job,
    output logic              job_ready,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [55:0]       m_tdata,   // reg_offset, write_byte, data_word, word_address
    output logic [2:0]        m_tuser,   // kind
    output logic              m_tlast
);
    import apcsr_pkg::*;

    localparam logic [15:0] BURST_COUNT = 16'(BURST_SECTORS);

    job_t        job_reg;
    logic        valid_reg;
    logic [3:0]  idx_reg;

    kind_t       kind;
    logic [2:0]  reg_offset;
    logic [7:0]  write_byte;
    logic [15:0] data_word;
    logic [24:0] word_address;
    logic [47:0] lba;
    logic        last;

    assign lba       = {32'd0, job_reg.sector};
    assign last      = (idx_reg == (mode_results(job_reg.mode) - 4'd1));
    assign job_ready = !valid_reg || (m_tready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (job_ready) begin
            valid_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready) begin
            job_reg <= job;
            idx_reg <= 4'd0;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_comb begin
        kind         = KIND_HIT;
        reg_offset   = 3'd0;
        write_byte   = 8'd0;
        data_word    = 16'd0;
        word_address = 25'd0;
        unique case (job_reg.mode)
            MODE_HIT: begin
                kind = KIND_HIT;
            end
            MODE_CMD: begin
                kind = KIND_WRITE;
                case (idx_reg)
                    4'd0: begin
                        reg_offset = REG_COUNT;
                        write_byte = BURST_COUNT[15:8];
                    end
                    4'd1: begin
                        reg_offset = REG_LBA_LOW;
                        write_byte = lba[31:24];
                    end
                    4'd2: begin
                        reg_offset = REG_LBA_MID;
                        write_byte = lba[39:32];
                    end
                    4'd3: begin
                        reg_offset = REG_LBA_HIGH;
                        write_byte = lba[47:40];
                    end
                    4'd4: begin
                        reg_offset = REG_COUNT;
                        write_byte = BURST_COUNT[7:0];
                    end
                    4'd5: begin
                        reg_offset = REG_LBA_LOW;
                        write_byte = lba[7:0];
                    end
                    4'd6: begin
                        reg_offset = REG_LBA_MID;
                        write_byte = lba[15:8];
                    end
                    4'd7: begin
                        reg_offset = REG_LBA_HIGH;
                        write_byte = lba[23:16];
                    end
                    4'd8: begin
                        reg_offset = REG_COMMAND;
                        write_byte = CMD_READ_EXT;
                    end
                    default: begin
                        kind       = KIND_BREAD;
                        reg_offset = REG_STATUS;
                    end
                endcase
            end
            MODE_BREAD: begin
                kind       = KIND_BREAD;
                reg_offset = REG_STATUS;
            end
            MODE_WREAD: begin
                kind       = KIND_WREAD;
                reg_offset = REG_DATA;
            end
            MODE_DONE: begin
                kind = KIND_DONE;
            end
            MODE_ERROR: begin
                kind = KIND_ERROR;
            end
            MODE_DATA_WREAD, MODE_DATA_BREAD: begin
                if (idx_reg == 4'd0) begin
                    kind         = KIND_DATA;
                    data_word    = job_reg.data_word;
                    word_address = job_reg.word_address;
                end else if (job_reg.mode == MODE_DATA_WREAD) begin
                    kind       = KIND_WREAD;
                    reg_offset = REG_DATA;
                end else begin
                    kind       = KIND_BREAD;
                    reg_offset = REG_STATUS;
                end
            end
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind;
    assign m_tlast  = last;
    assign m_tdata  = {4'd0, word_address, data_word, write_byte, reg_offset};

endmodule

`default_nettype wire

@@ hw/rtl/ata_pio_cached_sector_reader.sv @@
// Cached ATA PIO sector reader: request and response sequencer over a two-bank presence map.
// An item's first result is offered once the item moves from the input register into the
// result sequencer. Throughput: one item per cycle while each item yields one result and
// m_tready is high; the result port gives one result per cycle, so a missed request holds
// it for ten results and a data word for two. Reset: synchronous; a clearing pass then
// zeroes the map, accepting no item meanwhile. Depends on apcsr_pkg and apcsr_result_seq.
`default_nettype none

module ata_pio_cached_sector_reader #(
    parameter int MAP_SECTORS   = 65536,
    parameter int BURST_SECTORS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // byte_offset, response_value
    input  wire  [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // reg_offset, write_byte, data_word, word_address
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import apcsr_pkg::*;

    localparam int NROWS      = (MAP_SECTORS + 31) / 32;
    localparam int BANK_DEPTH = (NROWS + 1) / 2;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int XW         = AW + 11;
    localparam logic [31:0] MAP_LIMIT = 32'(MAP_SECTORS);
    localparam logic [63:0] BURST_ONES = {{(64 - BURST_SECTORS){1'b0}}, {BURST_SECTORS{1'b1}}};

    // Presence map, 32 sectors per row; even rows in one bank and odd rows in the other,
    // so a sector and its successor row are always read together.
    logic [31:0] mem_even [BANK_DEPTH];
    logic [31:0] mem_odd  [BANK_DEPTH];
    logic [31:0] rd_even_reg;
    logic [31:0] rd_odd_reg;

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          a_valid_reg;
    logic [1:0]    a_op_reg;
    logic [24:0]   a_offs_reg;
    logic [15:0]   a_resp_reg;

    phase_t        phase_reg, phase_next;
    logic [16:0]   cur_sector_reg, cur_sector_next;
    logic [4:0]    sleft_reg, sleft_next;
    logic [7:0]    widx_reg, widx_next;
    logic [2:0]    dummy_reg, dummy_next;

    logic          s_accept;
    logic [11:0]   s_row_inc;
    logic [XW-1:0] ev_ra_wide;
    logic [XW-1:0] od_ra_wide;

    logic [10:0]   a_row;
    logic [11:0]   a_row_inc;
    logic [XW-1:0] ev_wa_wide;
    logic [XW-1:0] od_wa_wide;
    logic [4:0]    a_off;
    logic [5:0]    a_off_inc;
    logic [63:0]   window;
    logic [63:0]   inmap;
    logic [63:0]   wmask;
    logic [63:0]   window_new;
    logic          hit;
    logic [7:0]    st;
    logic [4:0]    sleft_dec;
    logic [2:0]    dummy_dec;

    logic          produce;
    logic          map_we;
    logic          a_adv;
    job_t          job;
    logic          job_ready;

    logic          ev_we, od_we;
    logic [AW-1:0] ev_wa, od_wa;
    logic [31:0]   ev_wd, od_wd;

    assign s_accept   = s_tvalid && s_tready;
    assign s_row_inc  = {1'b0, s_tdata[24:14]} + 12'd1;
    assign ev_ra_wide = XW'(s_row_inc[11:1]);
    assign od_ra_wide = XW'(s_tdata[24:15]);

    always_ff @(posedge aclk) begin
        if (ev_we) begin
            mem_even[ev_wa] <= ev_wd;
        end
        if (s_accept) begin
            rd_even_reg <= mem_even[ev_ra_wide[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (od_we) begin
            mem_odd[od_wa] <= od_wd;
        end
        if (s_accept) begin
            rd_odd_reg <= mem_odd[od_ra_wide[AW-1:0]];
        end
    end

    // Row r sits in the low half of the window, row r+1 in the high half.
    assign a_row      = a_offs_reg[24:14];
    assign a_row_inc  = {1'b0, a_row} + 12'd1;
    assign ev_wa_wide = XW'(a_row_inc[11:1]);
    assign od_wa_wide = XW'(a_row[10:1]);
    assign a_off      = a_offs_reg[13:9];
    assign a_off_inc  = {1'b0, a_off} + 6'd1;
    assign window     = a_row[0] ? {rd_even_reg, rd_odd_reg} : {rd_odd_reg, rd_even_reg};

    always_comb begin
        logic [16:0] sec;
        for (int k = 0; k < 64; k++) begin
            sec      = {1'b0, a_row, 5'd0} + 17'(k);
            inmap[k] = (32'(sec) < MAP_LIMIT);
        end
    end

    assign hit        = window[{1'b0, a_off}] && inmap[{1'b0, a_off}] &&
                        window[a_off_inc] && inmap[a_off_inc];
    assign wmask      = (BURST_ONES << a_off) & inmap;
    assign window_new = window | wmask;
    assign st         = a_resp_reg[7:0];
    assign sleft_dec  = sleft_reg - 5'd1;
    assign dummy_dec  = dummy_reg - 3'd1;

    always_comb begin
        phase_next      = phase_reg;
        cur_sector_next = cur_sector_reg;
        sleft_next      = sleft_reg;
        widx_next       = widx_reg;
        dummy_next      = dummy_reg;
        produce         = 1'b0;
        map_we          = 1'b0;
        job.mode         = MODE_HIT;
        job.sector       = a_offs_reg[24:9];
        job.data_word    = a_resp_reg;
        job.word_address = {cur_sector_reg, widx_reg};
        if (a_valid_reg) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (a_op_reg == OP_REQUEST) begin
                        produce = 1'b1;
                        if (hit) begin
                            job.mode = MODE_HIT;
                        end else begin
                            job.mode        = MODE_CMD;
                            map_we          = 1'b1;
                            cur_sector_next = {1'b0, a_offs_reg[24:9]};
                            sleft_next      = 5'(BURST_SECTORS);
                            widx_next       = 8'd0;
                            dummy_next      = 3'd0;
                            phase_next      = PH_DISCARD;
                        end
                    end
                end
                PH_DISCARD: begin
                    if (a_op_reg == OP_BYTE_RESP) begin
                        produce    = 1'b1;
                        job.mode   = MODE_BREAD;
                        phase_next = PH_POLL;
                    end
                end
                PH_POLL: begin
                    if (a_op_reg == OP_BYTE_RESP) begin
                        produce = 1'b1;
                        priority if (!st[ST_BSY] && st[ST_DRQ]) begin
                            job.mode   = MODE_WREAD;
                            widx_next  = 8'd0;
                            phase_next = PH_DATA;
                        end else if (st[ST_ERR] || st[ST_DF]) begin
                            job.mode   = MODE_ERROR;
                            phase_next = PH_IDLE;
                        end else begin
                            job.mode = MODE_BREAD;
                        end
                    end
                end
                PH_DATA: begin
                    if (a_op_reg == OP_WORD_RESP) begin
                        produce = 1'b1;
                        if (widx_reg != LAST_WORD) begin
                            job.mode  = MODE_DATA_WREAD;
                            widx_next = widx_reg + 8'd1;
                        end else begin
                            job.mode   = MODE_DATA_BREAD;
                            widx_next  = 8'd0;
                            dummy_next = DUMMY_READS;
                            phase_next = PH_DUMMY;
                        end
                    end
                end
                PH_DUMMY: begin
                    if (a_op_reg == OP_BYTE_RESP) begin
                        produce    = 1'b1;
                        dummy_next = dummy_dec;
                        if (dummy_dec != 3'd0) begin
                            job.mode = MODE_BREAD;
                        end else begin
                            sleft_next      = sleft_dec;
                            cur_sector_next = cur_sector_reg + 17'd1;
                            if (sleft_dec != 5'd0) begin
                                job.mode   = MODE_BREAD;
                                phase_next = PH_DISCARD;
                            end else begin
                                job.mode   = MODE_DONE;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign a_adv    = a_valid_reg && (!produce || job_ready);
    assign s_tready = !clearing_reg && (!a_valid_reg || a_adv);

    // A request read in the cycle of a miss write-back sees the old rows, but a miss
    // leaves the phase busy, so that request is dropped without looking at them.
    always_comb begin
        ev_we = clearing_reg;
        od_we = clearing_reg;
        ev_wa = clr_addr_reg;
        od_wa = clr_addr_reg;
        ev_wd = 32'd0;
        od_wd = 32'd0;
        if (!clearing_reg && map_we && a_adv) begin
            ev_wa = ev_wa_wide[AW-1:0];
            od_wa = od_wa_wide[AW-1:0];
            if (a_row[0]) begin
                ev_we = |wmask[63:32];
                od_we = |wmask[31:0];
                ev_wd = window_new[63:32];
                od_wd = window_new[31:0];
            end else begin
                ev_we = |wmask[31:0];
                od_we = |wmask[63:32];
                ev_wd = window_new[31:0];
                od_wd = window_new[63:32];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(BANK_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_op_reg   <= s_tuser;
            a_offs_reg <= s_tdata[24:0];
            a_resp_reg <= s_tdata[40:25];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            cur_sector_reg <= 17'd0;
            sleft_reg      <= 5'd0;
            widx_reg       <= 8'd0;
            dummy_reg      <= 3'd0;
        end else if (a_adv) begin
            phase_reg      <= phase_next;
            cur_sector_reg <= cur_sector_next;
            sleft_reg      <= sleft_next;
            widx_reg       <= widx_next;
            dummy_reg      <= dummy_next;
        end
    end

    apcsr_result_seq #(
        .BURST_SECTORS (BURST_SECTORS)
    ) u_result_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (a_valid_reg && produce),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/apcsr_checker.sv @@
// Port checker for the cached ATA PIO sector reader, bound to the top level.
// Depends on apcsr_pkg and ata_pio_cached_sector_reader.
`default_nettype none

module apcsr_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);
    import apcsr_pkg::*;

    // A stalled result item holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Reset empties the result register and starts the map clearing pass.
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("item accepted during the map clearing pass");

    // Only register writes carry a write byte.
    a_byte_only_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_WRITE) |-> (m_tdata[10:3] == 8'd0))
        else $error("write byte set on a result that is not a write");

    // Hit, done and error are the only result of their item.
    a_single_results: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_HIT || m_tuser == KIND_DONE || m_tuser == KIND_ERROR)
            |-> m_tlast)
        else $error("hit, done or error result not marked last");

endmodule

bind ata_pio_cached_sector_reader apcsr_checker u_apcsr_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the cached ATA PIO sector reader: drives request and
// bus response items, predicts every result from its own copy of the block's state
// and checks each one field by field. Depends on apcsr_pkg and the block's RTL.
`default_nettype none

module testbench;
    import apcsr_pkg::*;

    localparam int MAP_SECTORS   = 65536;
    localparam int BURST_SECTORS = 8;
    localparam int RANDOM_ITEMS  = 430;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  reg_offset;
        logic [7:0]  write_byte;
        logic [15:0] data_word;
        logic [24:0] word_address;
        logic        last;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata = '0;   // byte_offset, response_value
    logic [1:0]  s_tuser = '0;   // operation
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [55:0] m_tdata;        // reg_offset, write_byte, data_word, word_address
    wire  [2:0]  m_tuser;        // kind
    wire         m_tlast;

    ata_pio_cached_sector_reader #(
        .MAP_SECTORS  (MAP_SECTORS),
        .BURST_SECTORS(BURST_SECTORS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    bus_result_t expected_results[$];
    bit          sector_marks[MAP_SECTORS];
    phase_t      rd_phase = PH_IDLE;
    logic [16:0] cur_sector = '0;
    logic [4:0]  sectors_left = '0;
    logic [8:0]  word_idx = '0;
    logic [2:0]  dummy_left = '0;

    int mismatches = 0;
    int active_items = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    function automatic bit is_cached(input int sector);
        return sector < MAP_SECTORS && sector_marks[sector];
    endfunction

    function automatic void push_result(input kind_t kind, input logic [2:0] reg_offset,
                                        input logic [7:0] write_byte,
                                        input logic [15:0] data_word,
                                        input logic [24:0] word_address);
        bus_result_t r;
        r.kind         = kind;
        r.reg_offset   = reg_offset;
        r.write_byte   = write_byte;
        r.data_word    = data_word;
        r.word_address = word_address;
        r.last         = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Advances the local copy of the sequencer by one accepted item and queues the
    // results it causes; returns how many there are.
    function automatic int predict_item(input logic [1:0] op, input logic [24:0] offs,
                                        input logic [15:0] resp);
        int          first;
        int          sector;
        logic [47:0] lba;
        logic [15:0] cnt;
        logic [7:0]  st;
        bit          ready;
        bit          fault;
        bus_result_t tail;
        first  = expected_results.size();
        st     = resp[7:0];
        ready  = !st[ST_BSY] && st[ST_DRQ];
        fault  = st[ST_ERR] || st[ST_DF];
        sector = int'(offs >> 9);
        lba    = 48'(sector);
        cnt    = 16'(BURST_SECTORS);
        if (op == OP_REQUEST && rd_phase == PH_IDLE) begin
            if (is_cached(sector) && is_cached(sector + 1)) begin
                push_result(KIND_HIT, '0, '0, '0, '0);
            end else begin
                for (int j = 0; j < BURST_SECTORS; j++) begin
                    if (sector + j < MAP_SECTORS) begin
                        sector_marks[sector + j] = 1'b1;
                    end
                end
                push_result(KIND_WRITE, REG_COUNT, cnt[15:8], '0, '0);
                push_result(KIND_WRITE, REG_LBA_LOW, lba[31:24], '0, '0);
                push_result(KIND_WRITE, REG_LBA_MID, lba[39:32], '0, '0);
                push_result(KIND_WRITE, REG_LBA_HIGH, lba[47:40], '0, '0);
                push_result(KIND_WRITE, REG_COUNT, cnt[7:0], '0, '0);
                push_result(KIND_WRITE, REG_LBA_LOW, lba[7:0], '0, '0);
                push_result(KIND_WRITE, REG_LBA_MID, lba[15:8], '0, '0);
                push_result(KIND_WRITE, REG_LBA_HIGH, lba[23:16], '0, '0);
                push_result(KIND_WRITE, REG_COMMAND, CMD_READ_EXT, '0, '0);
                push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
                cur_sector   = 17'(sector);
                sectors_left = 5'(BURST_SECTORS);
                word_idx     = '0;
                dummy_left   = '0;
                rd_phase     = PH_DISCARD;
            end
        end else if (op == OP_BYTE_RESP && rd_phase == PH_DISCARD) begin
            push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
            rd_phase = PH_POLL;
        end else if (op == OP_BYTE_RESP && rd_phase == PH_POLL) begin
            if (ready) begin
                word_idx = '0;
                push_result(KIND_WREAD, REG_DATA, '0, '0, '0);
                rd_phase = PH_DATA;
            end else if (fault) begin
                push_result(KIND_ERROR, '0, '0, '0, '0);
                rd_phase = PH_IDLE;
            end else begin
                push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
            end
        end else if (op == OP_WORD_RESP && rd_phase == PH_DATA) begin
            push_result(KIND_DATA, '0, '0, resp, 25'(cur_sector) * 25'd256 + 25'(word_idx));
            if (word_idx < 9'd255) begin
                word_idx = word_idx + 9'd1;
                push_result(KIND_WREAD, REG_DATA, '0, '0, '0);
            end else begin
                word_idx   = '0;
                dummy_left = DUMMY_READS;
                push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
                rd_phase = PH_DUMMY;
            end
        end else if (op == OP_BYTE_RESP && rd_phase == PH_DUMMY) begin
            dummy_left = dummy_left - 3'd1;
            if (dummy_left != 0) begin
                push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
            end else begin
                sectors_left = sectors_left - 5'd1;
                cur_sector   = cur_sector + 17'd1;
                if (sectors_left != 0) begin
                    push_result(KIND_BREAD, REG_STATUS, '0, '0, '0);
                    rd_phase = PH_DISCARD;
                end else begin
                    push_result(KIND_DONE, '0, '0, '0, '0);
                    rd_phase = PH_IDLE;
                end
            end
        end
        if (expected_results.size() > first) begin
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
        return expected_results.size() - first;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [24:0] offs,
                             input logic [15:0] resp);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            quiet_tx = !quiet_tx;
        end
        gap = quiet_tx ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, resp, offs};
        do @(posedge aclk); while (!s_tready);
        if (predict_item(op, offs, resp) > 0) begin
            active_items++;
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Picks the item that the sequencer is waiting for, with some stray items mixed in.
    task automatic play_next(input bit allow_fault);
        logic [1:0]  op;
        logic [24:0] offs;
        logic [15:0] resp;
        logic [7:0]  st;
        int          pick;
        int          r;
        offs = 25'($urandom);
        resp = 16'($urandom);
        pick = $urandom_range(0, 99);
        op   = OP_BYTE_RESP;
        if (pick < 6) begin
            op = 2'($urandom_range(0, 3));
        end else begin
            case (rd_phase)
                PH_IDLE: begin
                    op = OP_REQUEST;
                    r  = $urandom_range(0, 9);
                    if (r < 5) begin
                        offs = {16'($urandom_range(0, 47)), 9'($urandom)};
                    end else if (r < 7) begin
                        offs = {16'($urandom_range(65528, 65535)), 9'($urandom)};
                    end
                end
                PH_POLL: begin
                    r  = $urandom_range(0, 99);
                    st = 8'($urandom);
                    if (r < (allow_fault ? 85 : 40)) begin
                        if ($urandom_range(0, 1)) begin
                            st[ST_DRQ] = 1'b0;
                        end else begin
                            st[ST_BSY] = 1'b1;
                        end
                        if (allow_fault && r < 45) begin
                            if ($urandom_range(0, 1)) begin
                                st[ST_ERR] = 1'b1;
                            end else begin
                                st[ST_DF] = 1'b1;
                            end
                        end else begin
                            st[ST_ERR] = 1'b0;
                            st[ST_DF]  = 1'b0;
                        end
                    end else if (!allow_fault || r >= 97) begin
                        st[ST_BSY] = 1'b0;
                        st[ST_DRQ] = 1'b1;
                    end else begin
                        st[ST_BSY] = 1'b1;
                        st[ST_ERR] = 1'b1;
                    end
                    resp[7:0] = st;
                end
                PH_DATA: op = OP_WORD_RESP;
                default: op = OP_BYTE_RESP;
            endcase
        end
        send_item(op, offs, resp);
    endtask

    task automatic test_stray_items();
        send_item(OP_BYTE_RESP, '0, 16'h0008);
        send_item(OP_WORD_RESP, '0, 16'hFFFF);
        send_item(OP_RESERVED, 25'h1FFFFFF, 16'hFFFF);
    endtask

    task automatic test_miss_then_fault();
        send_item(OP_REQUEST, 25'd0, 16'h0000);
        send_item(OP_REQUEST, 25'h1FFFFFF, 16'h0000);
        send_item(OP_WORD_RESP, '0, 16'h1234);
        send_item(OP_BYTE_RESP, '0, 16'hFFFF);
        send_item(OP_BYTE_RESP, '0, 16'h0080);
        send_item(OP_BYTE_RESP, '0, 16'hFF00);
        send_item(OP_BYTE_RESP, '0, 16'h0088);
        send_item(OP_BYTE_RESP, '0, 16'h0021);
    endtask

    task automatic test_hits_and_overlap();
        send_item(OP_REQUEST, 25'd511, 16'h0000);
        send_item(OP_REQUEST, 25'(7 * 512 + 5), 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0089);
        send_item(OP_REQUEST, 25'(8 * 512), 16'h0000);
        send_item(OP_REQUEST, 25'(14 * 512), 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0000);
        send_item(OP_RESERVED, '0, 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0020);
    endtask

    task automatic test_map_end();
        send_item(OP_REQUEST, 25'h1FFFFFF, 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'h0001);
        send_item(OP_REQUEST, 25'h1FFFE00, 16'hFFFF);
        send_item(OP_BYTE_RESP, '0, 16'h0000);
        send_item(OP_BYTE_RESP, '0, 16'hFFA1);
    endtask

    // A whole burst near the top of the map, so that the sector count runs past its end.
    task automatic test_full_burst();
        send_item(OP_REQUEST, {16'd65530, 9'($urandom)}, 16'($urandom));
        while (rd_phase != PH_IDLE) begin
            play_next(1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int start;
        start = active_items;
        while (active_items - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 24) == 0) begin
                wait_drain();
            end
            play_next(1'b1);
        end
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bus_result_t got;
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = kind_t'(m_tuser);
            got.reg_offset   = m_tdata[2:0];
            got.write_byte   = m_tdata[10:3];
            got.data_word    = m_tdata[26:11];
            got.word_address = m_tdata[51:27];
            got.last         = m_tlast;
            if (expected_results.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("Unexpected item: kind %0d reg %0d byte %02h word %04h addr %07h last %0d",
                             got.kind, got.reg_offset, got.write_byte, got.data_word,
                             got.word_address, got.last);
                end
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.reg_offset !== want.reg_offset ||
                        got.write_byte !== want.write_byte ||
                        got.data_word !== want.data_word ||
                        got.word_address !== want.word_address || got.last !== want.last) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("Mismatch: expected kind %0d reg %0d byte %02h word %04h addr %07h last %0d",
                                 want.kind, want.reg_offset, want.write_byte, want.data_word,
                                 want.word_address, want.last);
                        $display("          actual   kind %0d reg %0d byte %02h word %04h addr %07h last %0d",
                                 got.kind, got.reg_offset, got.write_byte, got.data_word,
                                 got.word_address, got.last);
                    end
                    mismatches++;
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                quiet_rx = !quiet_rx;
            end
            rx_hold = quiet_rx ? 0 : $urandom_range(0, 11);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_stray_items();
        test_miss_then_fault();
        test_hits_and_overlap();
        test_map_end();
        wait_drain();
        test_full_burst();
        test_random_traffic();
        wait_drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
